// ===== rtl/core/varispeed_ring_playback_top_defines.svh =====
// ----------------------------------------------------------------------------
// varispeed ring playback assertion macros
// shared property shorthands, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef VARISPEED_RING_PLAYBACK_TOP_DEFINES_SVH
`define VARISPEED_RING_PLAYBACK_TOP_DEFINES_SVH

// same-cycle implication
`define VRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// shared constants, codes and types of the varispeed ring playback block
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int RING_DEPTH = 65536;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam logic [RING_AW:0] RING_DEPTH_W = (RING_AW + 1)'(RING_DEPTH);

  // reciprocal for position modulo ring depth
  localparam int MOD_SHIFT = 31 + RING_AW;
  localparam longint unsigned MOD_RECIP_L = (64'd1 << MOD_SHIFT) / RING_DEPTH;
  localparam logic [31:0] MOD_RECIP = 32'(MOD_RECIP_L);
  localparam int MOD_QW = 64 - MOD_SHIFT;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_SEEK = 2'd2;

  localparam logic [1:0] CFG_RATE      = 2'd0;
  localparam logic [1:0] CFG_PLAY_EN   = 2'd1;
  localparam logic [1:0] CFG_TRACK_LEN = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [16:0] RATE_RESET      = 17'd65536;
  localparam logic        PLAY_EN_RESET   = 1'b1;
  localparam logic [31:0] TRACK_LEN_RESET = 32'd0;
  localparam logic [16:0] THRESHOLD_RESET = 17'd4096;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_RD0,
    SEQ_RD1,
    SEQ_RD2,
    SEQ_RD3
  } seq_state_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               req;
    logic               back;
  } res_t;

endpackage

// ===== rtl/core/vrp_ram.sv =====
// ----------------------------------------------------------------------------
// vrp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vrp_posmod.sv =====
// ----------------------------------------------------------------------------
// vrp_posmod
// integer play position modulo ring depth, reciprocal multiply pipeline
// ----------------------------------------------------------------------------
module vrp_posmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                n,
  output logic                       busy,
  output logic [vrp_pkg::RING_AW-1:0] rem
);

  logic                         v1, v2, v3;
  logic [31:0]                  n1, n2;
  logic [63:0]                  prod2;
  logic [vrp_pkg::RING_AW:0]    rem3;
  logic [vrp_pkg::MOD_QW-1:0]   quot;
  logic [31:0]                  qd;
  logic [31:0]                  diff;
  logic [vrp_pkg::RING_AW:0]    rem_fix;

  always_comb begin
    quot = prod2[vrp_pkg::MOD_SHIFT +: vrp_pkg::MOD_QW];
    qd   = 32'(quot) * 32'(vrp_pkg::RING_DEPTH);
    diff = n2 - qd;
    if (rem3 >= vrp_pkg::RING_DEPTH_W) begin
      rem_fix = rem3 - vrp_pkg::RING_DEPTH_W;
    end else begin
      rem_fix = rem3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      rem <= '0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        rem <= rem_fix[vrp_pkg::RING_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n1 <= n;
    end
    prod2 <= n1 * vrp_pkg::MOD_RECIP;
    n2    <= n1;
    rem3  <= diff[vrp_pkg::RING_AW:0];
  end

  assign busy = v1 | v2 | v3;

endmodule

// ===== rtl/core/vrp_lerp.sv =====
// ----------------------------------------------------------------------------
// vrp_lerp
// two stage linear interpolation a + frac*(b-a)/65536, truncated toward zero
// ----------------------------------------------------------------------------
module vrp_lerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               side,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic        [15:0] frac,
  output logic               done,
  output logic               done_side,
  output logic signed [15:0] y
);

  logic               v1, side1;
  logic signed [15:0] a1;
  logic signed [33:0] prod1;
  logic signed [16:0] diff;
  logic signed [16:0] frac_s;
  logic signed [34:0] num;
  logic signed [18:0] quot;
  logic signed [18:0] quot_fix;

  always_comb begin
    diff   = 17'(a) - 17'(a);
    diff   = 17'(b) - 17'(a);
    frac_s = signed'({1'b0, frac});
    num    = (35'(a1) <<< 16) + 35'(prod1);
    quot   = 19'(num >>> 16);
    if (num[34] && (num[15:0] != 16'd0)) begin
      quot_fix = quot + 19'sd1;
    end else begin
      quot_fix = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      done      <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1        <= a;
    side1     <= side;
    prod1     <= diff * frac_s;
    done_side <= side1;
    y         <= quot_fix[15:0];
  end

endmodule

// ===== rtl/core/vrp_outq.sv =====
// ----------------------------------------------------------------------------
// vrp_outq
// two entry result queue in front of the output channel
// ----------------------------------------------------------------------------
`include "varispeed_ring_playback_top_defines.svh"

module vrp_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vrp_pkg::res_t din,
  input  logic          pop,
  output logic          valid,
  output vrp_pkg::res_t head
);

  vrp_pkg::res_t slot0, slot1;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (count == 2'd2)) begin
      slot0 <= slot1;
    end else if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      slot0 <= din;
    end
    if (push && (((count == 2'd1) && !pop) || (count == 2'd2))) begin
      slot1 <= din;
    end
  end

  assign valid = (count != 2'd0);
  assign head  = slot0;

  `VRP_ASSERT_IMPLY(a_outq_no_overflow, push && !pop, count != 2'd2, "result queue overflow")

endmodule

// ===== rtl/core/varispeed_ring_playback_top.sv =====
// ----------------------------------------------------------------------------
// varispeed_ring_playback_top
// varispeed stereo playback from a ring of interleaved samples
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   mode, sample_in, seek_position
// out      out  out_valid / out_ready left_out, right_out, read_request, read_backward
// cfg      in   cfg_write_en          cfg_index, cfg_data
//
// play beat: four ring reads, RD0 to RD3, on the single read port; result via lerp and queue
// load beat: a single ring write; seek beat: held while the position modulo unit is busy
// after reset a clearing pass over all RING_DEPTH addresses zeroes the ring, in_ready low
// results queue two deep; in_ready drops while two play beats are outstanding
// ----------------------------------------------------------------------------
`include "varispeed_ring_playback_top_defines.svh"

module varispeed_ring_playback_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] sample_in,
  input  logic [31:0]        seek_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic               read_request,
  output logic               read_backward
);

  localparam int AW = vrp_pkg::RING_AW;

  logic [16:0] rate_q16;
  logic        play_enable;
  logic [31:0] track_length;
  logic [16:0] readahead_threshold;

  logic [AW-1:0] write_index;
  logic [47:0]   play_position;
  logic [31:0]   samples_loaded;

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  vrp_pkg::seq_state_t state, state_next;
  logic [1:0]    inflight;

  logic          acc, load_acc, frame_acc, seek_acc;
  logic [48:0]   pos_sum;
  logic [48:0]   pos_limit;
  logic [47:0]   pos_adv;
  logic [31:0]   seek_clamp;
  logic          mod_start;
  logic [31:0]   mod_n;
  logic          mod_busy;
  logic [AW-1:0] pos_mod;

  logic [AW-1:0] prev_addr;
  logic [AW-1:0] next_c, prev_r_c, next_r_c;
  logic [AW-1:0] next_addr, prev_r_addr, next_r_addr;
  logic [AW-1:0] raddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   rd_data;

  logic [15:0]        frac_cur, frac_tail;
  logic signed [15:0] la, ra;
  logic               rb_pending;
  logic               lerp_start, lerp_side;
  logic signed [15:0] lerp_a;
  logic [15:0]        lerp_frac;
  logic               lerp_done, lerp_done_side;
  logic signed [15:0] lerp_y;
  logic signed [15:0] left_hold;

  logic [AW:0]   dist_pw, dist_wp;
  logic          fwd, bwd;
  logic          req_hold, back_hold;

  logic          q_push, q_pop;
  vrp_pkg::res_t q_din, q_head;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] x, input logic [1:0] k);
    logic [AW:0] s;
    s = {1'b0, x} + (AW + 1)'(k);
    if (s >= vrp_pkg::RING_DEPTH_W) begin
      s = s - vrp_pkg::RING_DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // handshake and decode
  assign in_ready = !clr_active && !mod_busy && (inflight != 2'd2) &&
                    ((state == vrp_pkg::SEQ_IDLE) || (state == vrp_pkg::SEQ_RD3));
  assign acc       = in_valid && in_ready;
  assign load_acc  = acc && (mode == vrp_pkg::MODE_LOAD);
  assign frame_acc = acc && (mode == vrp_pkg::MODE_PLAY);
  assign seek_acc  = acc && (mode == vrp_pkg::MODE_SEEK);

  // position advance and clamp
  always_comb begin
    pos_sum   = {1'b0, play_position} + (play_enable ? 49'({rate_q16, 1'b0}) : 49'd0);
    pos_limit = {1'b0, track_length, 16'd0};
    if (pos_sum > pos_limit) begin
      pos_adv = pos_limit[47:0];
    end else begin
      pos_adv = pos_sum[47:0];
    end
    seek_clamp = (seek_position > track_length) ? track_length : seek_position;
    mod_start  = frame_acc || seek_acc;
    mod_n      = frame_acc ? pos_adv[47:16] : seek_clamp;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_q16            <= vrp_pkg::RATE_RESET;
      play_enable         <= vrp_pkg::PLAY_EN_RESET;
      track_length        <= vrp_pkg::TRACK_LEN_RESET;
      readahead_threshold <= vrp_pkg::THRESHOLD_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        vrp_pkg::CFG_RATE:      rate_q16            <= cfg_data[16:0];
        vrp_pkg::CFG_PLAY_EN:   play_enable         <= cfg_data[0];
        vrp_pkg::CFG_TRACK_LEN: track_length        <= cfg_data;
        vrp_pkg::CFG_THRESHOLD: readahead_threshold <= cfg_data[16:0];
      endcase
    end
  end

  // playback state and ring clear
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      play_position  <= '0;
      samples_loaded <= '0;
      clr_active     <= 1'b1;
      clr_addr       <= '0;
      state          <= vrp_pkg::SEQ_IDLE;
      inflight       <= 2'd0;
      rb_pending     <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(vrp_pkg::RING_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (load_acc) begin
        write_index    <= ring_add(write_index, 2'd1);
        samples_loaded <= samples_loaded + 32'd1;
      end else if (seek_acc) begin
        write_index    <= '0;
        samples_loaded <= '0;
      end
      if (frame_acc) begin
        play_position <= pos_adv;
      end else if (seek_acc) begin
        play_position <= {seek_clamp, 16'd0};
      end
      state      <= state_next;
      rb_pending <= (state == vrp_pkg::SEQ_RD3);
      inflight   <= inflight + (frame_acc ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0);
    end
  end

  // read sequencer, next state
  always_comb begin
    unique case (state)
      vrp_pkg::SEQ_IDLE: state_next = frame_acc ? vrp_pkg::SEQ_RD0 : vrp_pkg::SEQ_IDLE;
      vrp_pkg::SEQ_RD0:  state_next = vrp_pkg::SEQ_RD1;
      vrp_pkg::SEQ_RD1:  state_next = vrp_pkg::SEQ_RD2;
      vrp_pkg::SEQ_RD2:  state_next = vrp_pkg::SEQ_RD3;
      vrp_pkg::SEQ_RD3:  state_next = frame_acc ? vrp_pkg::SEQ_RD0 : vrp_pkg::SEQ_IDLE;
      default:           state_next = vrp_pkg::SEQ_IDLE;
    endcase
  end

  // read sequencer, addresses
  always_comb begin
    prev_addr = {pos_mod[AW-1:1], 1'b0};
    next_c    = ring_add(prev_addr, 2'd2);
    prev_r_c  = ring_add(prev_addr, 2'd1);
    next_r_c  = ring_add(next_c, 2'd1);
    unique case (state)
      vrp_pkg::SEQ_RD0: raddr = prev_addr;
      vrp_pkg::SEQ_RD1: raddr = next_addr;
      vrp_pkg::SEQ_RD2: raddr = prev_r_addr;
      vrp_pkg::SEQ_RD3: raddr = next_r_addr;
      default:          raddr = prev_addr;
    endcase
  end

  // refill check against the advanced position
  always_comb begin
    dist_wp = {1'b0, write_index} - {1'b0, pos_mod};
    if (pos_mod > write_index) begin
      dist_wp = dist_wp + vrp_pkg::RING_DEPTH_W;
    end
    dist_pw = {1'b0, pos_mod} - {1'b0, write_index};
    if (write_index > pos_mod) begin
      dist_pw = dist_pw + vrp_pkg::RING_DEPTH_W;
    end
    fwd = (32'(dist_wp) < 32'(readahead_threshold)) && (samples_loaded != track_length);
    bwd = (32'(dist_pw) < 32'(readahead_threshold)) &&
          (samples_loaded > 32'(vrp_pkg::RING_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (state == vrp_pkg::SEQ_RD0) begin
      next_addr   <= next_c;
      prev_r_addr <= prev_r_c;
      next_r_addr <= next_r_c;
    end
    if (frame_acc) begin
      frac_cur <= play_position[15:0];
    end
    if (state == vrp_pkg::SEQ_RD1) begin
      la <= signed'(rd_data);
    end
    if (state == vrp_pkg::SEQ_RD3) begin
      ra        <= signed'(rd_data);
      frac_tail <= frac_cur;
      req_hold  <= fwd || bwd;
      back_hold <= !fwd && bwd;
    end
    if (lerp_done && !lerp_done_side) begin
      left_hold <= lerp_y;
    end
  end

  // ring write port
  always_comb begin
    ram_we    = clr_active || load_acc;
    ram_waddr = clr_active ? clr_addr : write_index;
    ram_wdata = clr_active ? 16'd0 : sample_in;
  end

  vrp_ram #(
    .WIDTH (16),
    .DEPTH (vrp_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  vrp_posmod u_posmod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .n     (mod_n),
    .busy  (mod_busy),
    .rem   (pos_mod)
  );

  // left pair lands during the third read, right pair the cycle after the fourth
  assign lerp_start = (state == vrp_pkg::SEQ_RD2) || rb_pending;
  assign lerp_side  = rb_pending;
  assign lerp_a     = rb_pending ? ra : la;
  assign lerp_frac  = rb_pending ? frac_tail : frac_cur;

  vrp_lerp u_lerp (
    .clk       (clk),
    .rst       (rst),
    .start     (lerp_start),
    .side      (lerp_side),
    .a         (lerp_a),
    .b         (signed'(rd_data)),
    .frac      (lerp_frac),
    .done      (lerp_done),
    .done_side (lerp_done_side),
    .y         (lerp_y)
  );

  always_comb begin
    q_push      = lerp_done && lerp_done_side;
    q_din.left  = left_hold;
    q_din.right = lerp_y;
    q_din.req   = req_hold;
    q_din.back  = back_hold;
    q_pop       = out_valid && out_ready;
  end

  vrp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .valid (out_valid),
    .head  (q_head)
  );

  assign left_out      = q_head.left;
  assign right_out     = q_head.right;
  assign read_request  = q_head.req;
  assign read_backward = q_head.back;

  `VRP_ASSERT_IMPLY(a_clear_blocks_input, clr_active, !in_ready, "beat taken during ring clear")
  `VRP_ASSERT_IMPLY(a_posmod_settled, state == vrp_pkg::SEQ_RD3, !mod_busy, "position modulo late")
  `VRP_ASSERT_IMPLY(a_push_has_frame, q_push, inflight != 2'd0, "result without play beat")
  `VRP_ASSERT_NEXT(a_play_starts_reads, frame_acc, state == vrp_pkg::SEQ_RD0, "reads not started")

endmodule

// ===== dv/varispeed_ring_playback_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varispeed_ring_playback_top_test
// Checks the varispeed ring playback block against an in-bench model of the
// sample ring, the Q32.16 play position and the refill decision. A short table
// of directed beats and register writes runs first. Randomized
// seek/load/play sessions with noise beats follow under three idling phases,
// and the ring is then filled past its depth to reach the backward refill.
// ----------------------------------------------------------------------------
module varispeed_ring_playback_top_test;
  import vrp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_BEATS = 420;
  localparam res_t NO_FRAME = '0;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic [31:0]        word;
    logic               typed;
    res_t               want;
  } plan_row_t;

  // op is the mode of a beat or the index of a register write
  // word is the seek position of a beat or the value of a register write
  plan_row_t directed_plan [36] = '{
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b1, NO_FRAME},
    '{ROW_BEAT, MODE_UNUSED,   16'sh7FFF,   32'hFFFF_FFFF, 1'b0, NO_FRAME},
    '{ROW_REG,  CFG_TRACK_LEN, 16'sd0,      32'hFFFF_FFFF, 1'b0, NO_FRAME},
    '{ROW_REG,  CFG_RATE,      16'sd0,      32'h0001_FFFF, 1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_SEEK,     16'sd0,      32'hFFFF_FFFF, 1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_SEEK,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh7FFF,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh8000,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh8000,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh7FFF,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh5555,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'shAAAA,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b1,
      '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0}},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_RATE,      16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_RATE,      16'sd0,      32'd1,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_PLAY_EN,   16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_PLAY_EN,   16'sd0,      32'd1,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_THRESHOLD, 16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_THRESHOLD, 16'sd0,      32'h0001_0000, 1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_TRACK_LEN, 16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_SEEK,     16'sd0,      32'd1234,      1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_REG,  CFG_TRACK_LEN, 16'sd0,      32'd6,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_SEEK,     16'sd0,      32'd3,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'shFFFF,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_LOAD,     16'sh0001,   32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME},
    '{ROW_BEAT, MODE_PLAY,     16'sd0,      32'd0,         1'b0, NO_FRAME}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_LOAD;
  logic signed [15:0] sample_in = '0;
  logic [31:0]        seek_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               read_request;
  logic               read_backward;

  // playback model state
  logic signed [15:0] ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] wr_ptr;
  longint unsigned    pos_q16;
  logic [31:0]        loaded_cnt;
  logic [16:0]        rate_q16_r;
  logic               play_en_r;
  logic [31:0]        track_len_r;
  logic [16:0]        thresh_r;

  res_t   frames_due [$];
  int     errors = 0;
  int     beats_sent = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;

  varispeed_ring_playback_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [15:0] lerp_trunc(input logic signed [15:0] a,
                                                    input logic signed [15:0] b,
                                                    input longint frac);
    longint num;
    num = longint'(a) * 65536 + frac * (longint'(b) - longint'(a));
    return 16'(num / 65536);
  endfunction

  function automatic longint unsigned ring_gap(input longint unsigned s,
                                               input longint unsigned e);
    return (s > e) ? e + RING_DEPTH - s : e - s;
  endfunction

  function automatic bit advance_playback(input logic [1:0] m,
                                          input logic signed [15:0] s,
                                          input logic [31:0] sp,
                                          output res_t frame);
    longint unsigned ipos, lo, hi, limit, p;
    longint frac;
    frame = NO_FRAME;
    case (m)
      MODE_LOAD: begin
        ring_mem[wr_ptr] = s;
        wr_ptr = wr_ptr + 1'b1;
        loaded_cnt = loaded_cnt + 1'b1;
        return 1'b0;
      end
      MODE_SEEK: begin
        pos_q16 = {16'd0, ((sp > track_len_r) ? track_len_r : sp), 16'd0};
        wr_ptr = '0;
        loaded_cnt = '0;
        return 1'b0;
      end
      MODE_PLAY: begin
        ipos = pos_q16 >> 16;
        frac = longint'(pos_q16 & 64'hFFFF);
        lo = (ipos % RING_DEPTH) & ~64'd1;
        hi = (lo + 2) % RING_DEPTH;
        frame.left = lerp_trunc(ring_mem[lo], ring_mem[hi], frac);
        frame.right = lerp_trunc(ring_mem[(lo + 1) % RING_DEPTH],
                                 ring_mem[(hi + 1) % RING_DEPTH], frac);
        if (play_en_r) pos_q16 = pos_q16 + (64'(rate_q16_r) << 1);
        limit = 64'(track_len_r) << 16;
        if (pos_q16 > limit) pos_q16 = limit;
        p = (pos_q16 >> 16) % RING_DEPTH;
        if (ring_gap(p, 64'(wr_ptr)) < thresh_r && loaded_cnt != track_len_r) begin
          frame.req = 1'b1;
        end else if (ring_gap(64'(wr_ptr), p) < thresh_r && loaded_cnt > RING_DEPTH) begin
          frame.req = 1'b1;
          frame.back = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    res_t frame, due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: left_out %0d right_out %0d", left_out, right_out);
          errors++;
        end else begin
          due = frames_due.pop_front();
          if (left_out !== due.left) begin
            $error("left_out: expected %0d, got %0d", due.left, left_out);
            errors++;
          end
          if (right_out !== due.right) begin
            $error("right_out: expected %0d, got %0d", due.right, right_out);
            errors++;
          end
          if (read_request !== due.req) begin
            $error("read_request: expected %0b, got %0b", due.req, read_request);
            errors++;
          end
          if (read_backward !== due.back) begin
            $error("read_backward: expected %0b, got %0b", due.back, read_backward);
            errors++;
          end
        end
      end
      if (in_valid && in_ready && advance_playback(mode, sample_in, seek_position, frame))
        frames_due.push_back(frame);
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("varispeed_ring_playback_top test failed");
      $finish;
    end
  end

  // valid stays high after a beat; the next call or a wait lowers it
  task automatic send_beat(input logic [1:0] m, input logic signed [15:0] s,
                           input logic [31:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    sample_in <= s;
    seek_position <= sp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (m != MODE_UNUSED) beats_sent++;
  endtask

  task automatic await_frames();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    await_frames();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    settle();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_RATE:      rate_q16_r = val[16:0];
      CFG_PLAY_EN:   play_en_r = val[0];
      CFG_TRACK_LEN: track_len_r = val;
      CFG_THRESHOLD: thresh_r = val[16:0];
    endcase
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_seek();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(2500);
    endcase
  endfunction

  // registers, a seek in most sessions, a burst of loads, then plays mixed with noise beats
  task automatic run_session();
    int n_load, n_play;
    bit tidy;
    logic [31:0] v;
    n_load = $urandom_range(48);
    n_play = $urandom_range(1, 24);
    tidy = ($urandom_range(9) != 0);
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: v = 0;
        1: v = 32'h1FFFF;
        2: v = 65536;
        3: v = $urandom_range(4096);
        default: v = $urandom_range(131071);
      endcase
      write_reg(CFG_RATE, v);
    end
    if ($urandom_range(1)) write_reg(CFG_PLAY_EN, ($urandom_range(3) != 0));
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0: v = 32'hFFFF_FFFF;
        1: v = $urandom;
        2: v = n_load;
        3: v = 0;
        default: v = $urandom_range(3000);
      endcase
      write_reg(CFG_TRACK_LEN, v);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(7))
        0: v = 0;
        1: v = 65536;
        2, 3: v = $urandom_range(64);
        default: v = $urandom_range(65536);
      endcase
      write_reg(CFG_THRESHOLD, v);
    end
    if (tidy) send_beat(MODE_SEEK, pick_sample(), pick_seek());
    repeat (n_load) send_beat(MODE_LOAD, pick_sample(), $urandom);
    repeat (n_play) begin
      if ($urandom_range(39) == 0) await_frames();
      case ($urandom_range(19))
        0: send_beat(MODE_LOAD, pick_sample(), $urandom);
        1: send_beat(MODE_SEEK, pick_sample(), pick_seek());
        2: send_beat(MODE_UNUSED, pick_sample(), $urandom);
        default: send_beat(MODE_PLAY, pick_sample(), $urandom);
      endcase
    end
  endtask

  initial begin
    int ph, mark, n_fill;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr = '0;
    pos_q16 = 0;
    loaded_cnt = '0;
    rate_q16_r = RATE_RESET;
    play_en_r = PLAY_EN_RESET;
    track_len_r = TRACK_LEN_RESET;
    thresh_r = THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 57;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        write_reg(directed_plan[i].op, directed_plan[i].word);
      end else begin
        send_beat(directed_plan[i].op, directed_plan[i].sample, directed_plan[i].word);
        if (directed_plan[i].typed) frames_due[frames_due.size() - 1] = directed_plan[i].want;
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 34 : 0;
      mark = beats_sent;
      while (beats_sent - mark < PHASE_BEATS) run_session();
    end

    // fill past the ring depth so the write pointer wraps and backward refills occur
    n_fill = RING_DEPTH + $urandom_range(1, 300);
    write_reg(CFG_TRACK_LEN, n_fill);
    write_reg(CFG_THRESHOLD, $urandom_range(512, 65536));
    write_reg(CFG_RATE, $urandom_range(131071));
    write_reg(CFG_PLAY_EN, 1);
    send_beat(MODE_SEEK, pick_sample(), $urandom_range(400));
    repeat (n_fill) send_beat(MODE_LOAD, pick_sample(), $urandom);
    repeat (40) send_beat(MODE_PLAY, pick_sample(), $urandom);

    settle();
    if (errors == 0) begin
      $display("varispeed_ring_playback_top test passed");
    end else begin
      $display("varispeed_ring_playback_top test failed");
    end
    $finish;
  end

endmodule

// ===== varispeed_ring_playback_top.f =====
+incdir+rtl/core
rtl/core/vrp_pkg.sv
rtl/core/vrp_ram.sv
rtl/core/vrp_posmod.sv
rtl/core/vrp_lerp.sv
rtl/core/vrp_outq.sv
rtl/core/varispeed_ring_playback_top.sv
dv/varispeed_ring_playback_top_test.sv
